[rtl/core/tls_pkg.sv]
// Package: constants, register indexes and lookup functions for the traffic light sequencer.
`timescale 1ns / 1ps
package tls_pkg;

  localparam int unsigned POLL_W  = 24;
  localparam int unsigned SLICE_W = 8;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned LED_W   = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [POLL_W-1:0]  POLLS_PER_SLICE_RST  = 24'd490001;
  localparam logic [SLICE_W-1:0] SLICES_PER_COUNT_RST = 8'd20;
  localparam logic [COUNT_W-1:0] LONG_COUNT_RST       = 3'd7;
  localparam logic [COUNT_W-1:0] SHORT_COUNT_RST      = 3'd2;
  localparam logic [COUNT_W-1:0] FLASH_COUNT_RST      = 3'd2;

  localparam logic [PHASE_W-1:0] WALK_A_PHASE = 3'd0;
  localparam logic [PHASE_W-1:0] WALK_B_PHASE = 3'd4;
  localparam logic [LED_W-1:0]   PHASE_COUNTER_RST = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLLS_PER_SLICE  = 3'd0,
    REG_SLICES_PER_COUNT = 3'd1,
    REG_LONG_COUNT       = 3'd2,
    REG_SHORT_COUNT      = 3'd3,
    REG_FLASH_COUNT      = 3'd4
  } cfg_reg_t;

  function automatic logic [7:0] lamp_of(input logic [PHASE_W-1:0] p);
    logic [7:0] v;
    case (p)
      3'd0: v = 8'h18;
      3'd1: v = 8'h28;
      3'd2: v = 8'hC8;
      3'd3: v = 8'hA8;
      3'd4: v = 8'h81;
      3'd5: v = 8'h82;
      3'd6: v = 8'h8C;
      3'd7: v = 8'h8A;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] digit_of(input logic [COUNT_W-1:0] c);
    logic [7:0] v;
    case (c)
      3'd0: v = 8'h00;
      3'd1: v = 8'h61;
      3'd2: v = 8'hDB;
      3'd3: v = 8'hF3;
      3'd4: v = 8'h67;
      3'd5: v = 8'hB7;
      3'd6: v = 8'h3F;
      3'd7: v = 8'hE5;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/tls_if.sv]
// Interfaces: button poll, lamp result and configuration write channels.
`timescale 1ns / 1ps
interface tls_in_if;
  logic valid;
  logic ready;
  logic inner_button;
  logic outer_button_level;
  modport source (output valid, inner_button, outer_button_level, input ready);
  modport sink (input valid, inner_button, outer_button_level, output ready);
endinterface

interface tls_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] lamp_pattern;
  logic [7:0] segment_pattern;
  logic       walk_a_lit;
  logic       walk_b_lit;
  logic [3:0] led_value;
  logic [2:0] phase_index;
  modport source (output valid, lamp_pattern, segment_pattern, walk_a_lit, walk_b_lit,
                  led_value, phase_index, input ready);
  modport sink (input valid, lamp_pattern, segment_pattern, walk_a_lit, walk_b_lit,
                led_value, phase_index, output ready);
endinterface

interface tls_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/traffic_light_sequencer_unit.sv]
// The result of an accepted poll transaction is registered before it is shown on result_out.
// Throughput: one poll transaction per cycle; the result register takes a new
// transaction whenever it is empty or being drained in the same cycle.
// Reset (rst, synchronous): phase 0 with walk lamp A lit, count at long_count,
// phase counter 1, LEDs dark, registers at their default values, no result held.
`timescale 1ns / 1ps
module traffic_light_sequencer_unit
  import tls_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  tls_in_if.sink     item_in,
  tls_out_if.source  result_out,
  tls_cfg_if.sink    cfg
);

  logic [POLL_W-1:0]  polls_per_slice;
  logic [SLICE_W-1:0] slices_per_count;
  logic [COUNT_W-1:0] long_count;
  logic [COUNT_W-1:0] short_count;
  logic [COUNT_W-1:0] flash_count;

  logic [PHASE_W-1:0] phase, phase_next;
  logic [COUNT_W-1:0] count_left, count_left_next;
  logic [SLICE_W-1:0] slice_index, slice_index_next;
  logic [POLL_W-1:0]  poll_index, poll_index_next;
  logic [LED_W-1:0]   phase_counter, phase_counter_next;
  logic [LED_W-1:0]   shown_leds, shown_leds_next;
  logic               inner_held, inner_held_next;
  logic               outer_held, outer_held_next;
  logic               walk_a, walk_a_next;
  logic               walk_b, walk_b_next;

  logic               out_valid;
  logic [7:0]         lamp_reg;
  logic [7:0]         segment_reg;
  logic               walk_a_reg;
  logic               walk_b_reg;
  logic [LED_W-1:0]   led_reg;
  logic [PHASE_W-1:0] phase_reg;

  logic               accept;
  logic [POLL_W-1:0]  pps_eff;
  logic [SLICE_W-1:0] spc_eff;
  logic [POLL_W-1:0]  poll_inc;
  logic [SLICE_W-1:0] slice_inc;
  logic [COUNT_W-1:0] count_dec;
  logic [COUNT_W-1:0] load_count;
  logic [PHASE_W-1:0] phase_inc;
  logic               ended;
  logic               count_ended;
  logic               slice_wrap;
  logic               count_wrap;

  assign cfg.ready     = 1'b1;
  assign item_in.ready = !out_valid || result_out.ready;
  assign accept        = item_in.valid && item_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      polls_per_slice  <= POLLS_PER_SLICE_RST;
      slices_per_count <= SLICES_PER_COUNT_RST;
      long_count       <= LONG_COUNT_RST;
      short_count      <= SHORT_COUNT_RST;
      flash_count      <= FLASH_COUNT_RST;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_POLLS_PER_SLICE:  polls_per_slice  <= cfg.data;
        REG_SLICES_PER_COUNT: slices_per_count <= cfg.data[SLICE_W-1:0];
        REG_LONG_COUNT:       long_count       <= cfg.data[COUNT_W-1:0];
        REG_SHORT_COUNT:      short_count      <= cfg.data[COUNT_W-1:0];
        REG_FLASH_COUNT:      flash_count      <= cfg.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign pps_eff   = (polls_per_slice == '0) ? POLL_W'(1) : polls_per_slice;
  assign spc_eff   = (slices_per_count == '0) ? SLICE_W'(1) : slices_per_count;
  assign poll_inc  = poll_index + POLL_W'(1);
  assign slice_inc = slice_index + SLICE_W'(1);
  assign count_dec = count_left - COUNT_W'(1);
  assign phase_inc = phase + PHASE_W'(1);
  assign slice_wrap = (poll_inc >= pps_eff) || (poll_inc == '0);
  assign count_wrap = slice_wrap && ((slice_inc >= spc_eff) || (slice_inc == '0));
  assign count_ended = count_wrap && (count_dec == '0);

  always_comb begin
    logic outer_release;
    logic [COUNT_W-1:0] raw_count;
    outer_release      = 1'b0;
    raw_count          = '0;
    phase_next         = phase;
    count_left_next    = count_left;
    slice_index_next   = slice_index;
    poll_index_next    = poll_index;
    phase_counter_next = phase_counter;
    shown_leds_next    = shown_leds;
    inner_held_next    = inner_held;
    outer_held_next    = outer_held;
    walk_a_next        = walk_a;
    walk_b_next        = walk_b;
    load_count         = '0;

    if (item_in.inner_button) begin
      inner_held_next = 1'b1;
    end else if (inner_held) begin
      phase_counter_next = PHASE_COUNTER_RST;
      shown_leds_next    = '0;
      inner_held_next    = 1'b0;
    end

    if (!item_in.outer_button_level) begin
      outer_held_next = 1'b1;
    end else if (outer_held) begin
      outer_held_next = 1'b0;
      outer_release   = 1'b1;
    end

    ended = outer_release || count_ended;

    if (!outer_release) begin
      if (slice_wrap) begin
        poll_index_next = '0;
        if (count_wrap) begin
          slice_index_next = '0;
          count_left_next  = count_dec;
        end else begin
          slice_index_next = slice_inc;
        end
        if (!count_ended && (count_left_next <= flash_count)) begin
          if (phase == WALK_A_PHASE) begin
            walk_a_next = slice_index_next[0];
          end else if (phase == WALK_B_PHASE) begin
            walk_b_next = slice_index_next[0];
          end
        end
      end else begin
        poll_index_next = poll_inc;
      end
    end

    if (ended) begin
      shown_leds_next    = phase_counter_next;
      phase_counter_next = phase_counter_next + LED_W'(1);
      phase_next         = phase_inc;
      raw_count          = phase_inc[0] ? short_count : long_count;
      load_count         = (raw_count == '0) ? COUNT_W'(1) : raw_count;
      count_left_next    = load_count;
      slice_index_next   = '0;
      poll_index_next    = '0;
      inner_held_next    = 1'b0;
      outer_held_next    = 1'b0;
      walk_a_next        = (phase_inc == WALK_A_PHASE) && (load_count > flash_count);
      walk_b_next        = (phase_inc == WALK_B_PHASE) && (load_count > flash_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= '0;
      count_left    <= LONG_COUNT_RST;
      slice_index   <= '0;
      poll_index    <= '0;
      phase_counter <= PHASE_COUNTER_RST;
      shown_leds    <= '0;
      inner_held    <= 1'b0;
      outer_held    <= 1'b0;
      walk_a        <= (LONG_COUNT_RST > FLASH_COUNT_RST);
      walk_b        <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      count_left    <= count_left_next;
      slice_index   <= slice_index_next;
      poll_index    <= poll_index_next;
      phase_counter <= phase_counter_next;
      shown_leds    <= shown_leds_next;
      inner_held    <= inner_held_next;
      outer_held    <= outer_held_next;
      walk_a        <= walk_a_next;
      walk_b        <= walk_b_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lamp_reg    <= lamp_of(phase_next);
      segment_reg <= ((phase_next == WALK_A_PHASE) || (phase_next == WALK_B_PHASE)) ?
                     digit_of(count_left_next) : 8'h00;
      walk_a_reg  <= walk_a_next;
      walk_b_reg  <= walk_b_next;
      led_reg     <= shown_leds_next;
      phase_reg   <= phase_next;
    end
  end

  assign result_out.valid           = out_valid;
  assign result_out.lamp_pattern    = lamp_reg;
  assign result_out.segment_pattern = segment_reg;
  assign result_out.walk_a_lit      = walk_a_reg;
  assign result_out.walk_b_lit      = walk_b_reg;
  assign result_out.led_value       = led_reg;
  assign result_out.phase_index     = phase_reg;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted poll produced no result");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    count_left != '0)
    else $error("count_left reached zero inside a phase");

  a_blank_digit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (phase_reg != WALK_A_PHASE) && (phase_reg != WALK_B_PHASE))
      |-> (segment_reg == 8'h00))
    else $error("digit shown outside a walk phase");

  a_walk_b_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && walk_b_reg) |-> (phase_reg == WALK_B_PHASE))
    else $error("walk lamp B lit outside its phase");

  a_walk_a_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && walk_a_reg) |-> (phase_reg == WALK_A_PHASE))
    else $error("walk lamp A lit outside its phase");

endmodule
